[rtl/mrc_pkg.sv]
// ----------------------------------------------------------------------------
// mrc_pkg
// Shared types, constants and helpers of the memory range coalescer.
// ----------------------------------------------------------------------------
package mrc_pkg;

  localparam int unsigned PAGE_BITS  = 52;
  localparam int unsigned TYPE_BITS  = 4;
  localparam int unsigned ATTR_BITS  = 64;
  localparam int unsigned APB_DATA_BITS = 32;
  localparam int unsigned APB_ADDR_BITS = 3;

  localparam logic [PAGE_BITS-1:0] PAGE_MAX = {PAGE_BITS{1'b1}};

  // Register indexes (paddr[2])
  localparam logic REG_JOIN_TYPE_A = 1'b0;
  localparam logic REG_JOIN_TYPE_B = 1'b1;

  localparam logic [TYPE_BITS-1:0] JOIN_TYPE_A_RST = 4'd3;
  localparam logic [TYPE_BITS-1:0] JOIN_TYPE_B_RST = 4'd4;

  typedef struct packed {
    logic [TYPE_BITS-1:0] join_a;
    logic [TYPE_BITS-1:0] join_b;
  } cfg_t;

  typedef struct packed {
    logic [TYPE_BITS-1:0] mem_type;
    logic [PAGE_BITS-1:0] start;
    logic [PAGE_BITS-1:0] virt;
    logic [PAGE_BITS-1:0] pages;
    logic [ATTR_BITS-1:0] attr;
  } desc_t;

  typedef struct packed {
    desc_t desc;
    logic  last;
  } entry_t;

  // Up to two result beats per accepted descriptor
  typedef struct packed {
    logic [1:0] cnt;
    entry_t     e0;
    entry_t     e1;
  } push_t;

  function automatic logic joinable(cfg_t cfg, logic [TYPE_BITS-1:0] t);
    joinable = (t == cfg.join_a) || (t == cfg.join_b);
  endfunction

endpackage

[rtl/memory_range_coalescer.sv]
// ----------------------------------------------------------------------------
// memory_range_coalescer
// Merges adjacent memory-map descriptors of joinable types into one range.
// ----------------------------------------------------------------------------
// One descriptor beat is accepted per cycle and decided in that same cycle
// against the single pending descriptor register; a joined descriptor
// produces no result, a non-joining one emits the pending descriptor, and a
// final beat flushes with out_last set, so one input beat yields zero, one or
// two result beats. Results leave through a four-entry queue at one beat per
// cycle; input stalls while fewer than two queue slots are free, which
// happens when the output is held or when final beats that emit two results
// arrive faster than the queue drains.
// A result released by an accepted beat reaches the output in the next cycle
// when the queue is empty, and waits behind earlier results otherwise.
// The join types are set through the APB port at addresses 0 and 4.
module memory_range_coalescer (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // APB configuration
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [mrc_pkg::APB_ADDR_BITS-1:0]   paddr,
  input  logic [mrc_pkg::APB_DATA_BITS-1:0]   pwdata,
  output logic [mrc_pkg::APB_DATA_BITS-1:0]   prdata,
  output logic                                pready,
  // descriptor input
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic [mrc_pkg::TYPE_BITS-1:0]       mem_type_i,
  input  logic [mrc_pkg::PAGE_BITS-1:0]       start_page_i,
  input  logic [mrc_pkg::PAGE_BITS-1:0]       virt_page_i,
  input  logic [mrc_pkg::PAGE_BITS-1:0]       page_count_i,
  input  logic [mrc_pkg::ATTR_BITS-1:0]       attr_bits_i,
  input  logic                                is_final_i,
  // result output
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic [mrc_pkg::TYPE_BITS-1:0]       out_type_o,
  output logic [mrc_pkg::PAGE_BITS-1:0]       out_start_page_o,
  output logic [mrc_pkg::PAGE_BITS-1:0]       out_virt_page_o,
  output logic [mrc_pkg::PAGE_BITS-1:0]       out_pages_o,
  output logic [mrc_pkg::ATTR_BITS-1:0]       out_attr_o,
  output logic                                out_last_o
);

  mrc_pkg::cfg_t   cfg;
  mrc_pkg::entry_t in_beat;
  mrc_pkg::push_t  push;
  mrc_pkg::entry_t head;
  logic            room;
  logic            accept;

  mrc_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  assign in_stall_o = ~room;
  assign accept     = in_valid_i & room;

  assign in_beat.desc.mem_type = mem_type_i;
  assign in_beat.desc.start    = start_page_i;
  assign in_beat.desc.virt     = virt_page_i;
  assign in_beat.desc.pages    = page_count_i;
  assign in_beat.desc.attr     = attr_bits_i;
  assign in_beat.last          = is_final_i;

  mrc_merge u_merge (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .in_i     (in_beat),
    .cfg_i    (cfg),
    .push_o   (push)
  );

  mrc_out_fifo u_out_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .pop_i   (~out_stall_i),
    .room_o  (room),
    .valid_o (out_valid_o),
    .head_o  (head)
  );

  assign out_type_o       = head.desc.mem_type;
  assign out_start_page_o = head.desc.start;
  assign out_virt_page_o  = head.desc.virt;
  assign out_pages_o      = head.desc.pages;
  assign out_attr_o       = head.desc.attr;
  assign out_last_o       = head.last;

endmodule

[rtl/mrc_cfg.sv]
// ----------------------------------------------------------------------------
// mrc_cfg
// APB register file holding the two joinable memory type codes.
// ----------------------------------------------------------------------------
module mrc_cfg (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   psel,
  input  logic                                   penable,
  input  logic                                   pwrite,
  input  logic [mrc_pkg::APB_ADDR_BITS-1:0]      paddr,
  input  logic [mrc_pkg::APB_DATA_BITS-1:0]      pwdata,
  output logic [mrc_pkg::APB_DATA_BITS-1:0]      prdata,
  output logic                                   pready,
  output mrc_pkg::cfg_t                          cfg_o
);

  mrc_pkg::cfg_t cfg_q;
  logic          wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite & pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.join_a <= mrc_pkg::JOIN_TYPE_A_RST;
      cfg_q.join_b <= mrc_pkg::JOIN_TYPE_B_RST;
    end else if (wr_en) begin
      case (paddr[2])
        mrc_pkg::REG_JOIN_TYPE_A: cfg_q.join_a <= pwdata[mrc_pkg::TYPE_BITS-1:0];
        mrc_pkg::REG_JOIN_TYPE_B: cfg_q.join_b <= pwdata[mrc_pkg::TYPE_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    case (paddr[2])
      mrc_pkg::REG_JOIN_TYPE_A: prdata[mrc_pkg::TYPE_BITS-1:0] = cfg_q.join_a;
      mrc_pkg::REG_JOIN_TYPE_B: prdata[mrc_pkg::TYPE_BITS-1:0] = cfg_q.join_b;
      default: prdata = '0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule

[rtl/mrc_merge.sv]
// ----------------------------------------------------------------------------
// mrc_merge
// Pending descriptor register and the combinational join / emit decision.
// ----------------------------------------------------------------------------
module mrc_merge (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           accept_i,
  input  mrc_pkg::entry_t in_i,
  input  mrc_pkg::cfg_t  cfg_i,
  output mrc_pkg::push_t push_o
);

  logic                          held_valid_q, held_valid_d;
  mrc_pkg::desc_t                held_q, held_d;
  logic [mrc_pkg::PAGE_BITS:0]   end_page;
  logic [mrc_pkg::PAGE_BITS:0]   sum_pages;
  logic [mrc_pkg::PAGE_BITS-1:0] sat_pages;
  logic                          join_ok;
  logic                          emit_old;
  mrc_pkg::entry_t               old_res;
  mrc_pkg::entry_t               fin_res;

  // Exact end of the pending range: no wrap to page zero
  assign end_page  = {1'b0, held_q.start} + {1'b0, held_q.pages};
  assign sum_pages = {1'b0, held_q.pages} + {1'b0, in_i.desc.pages};
  assign sat_pages = sum_pages[mrc_pkg::PAGE_BITS] ? mrc_pkg::PAGE_MAX
                                                   : sum_pages[mrc_pkg::PAGE_BITS-1:0];

  assign join_ok = held_valid_q
                 && (in_i.desc.attr == held_q.attr)
                 && (end_page == {1'b0, in_i.desc.start})
                 && mrc_pkg::joinable(cfg_i, in_i.desc.mem_type)
                 && mrc_pkg::joinable(cfg_i, held_q.mem_type);

  assign emit_old = held_valid_q & ~join_ok;

  always_comb begin
    held_d = held_q;
    if (join_ok) begin
      held_d.pages = sat_pages;
    end else begin
      held_d = in_i.desc;
    end
  end

  assign held_valid_d = ~in_i.last;

  assign old_res.desc = held_q;
  assign old_res.last = 1'b0;
  assign fin_res.desc = held_d;
  assign fin_res.last = 1'b1;

  always_comb begin
    push_o.cnt = 2'd0;
    push_o.e0  = old_res;
    push_o.e1  = fin_res;
    if (accept_i) begin
      case ({emit_old, in_i.last})
        2'b10:   push_o.cnt = 2'd1;
        2'b11:   push_o.cnt = 2'd2;
        2'b01: begin
          push_o.cnt = 2'd1;
          push_o.e0  = fin_res;
        end
        default: push_o.cnt = 2'd0;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_valid_q <= 1'b0;
      held_q       <= '0;
    end else if (accept_i) begin
      held_valid_q <= held_valid_d;
      held_q       <= held_d;
    end
  end

`ifndef ASSERT_OFF
  a_final_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept_i && in_i.last) |=> !held_valid_q)
    else $error("pending descriptor survived a final beat");

  a_join_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept_i && join_ok && !in_i.last) |=> (held_q.pages >= $past(held_q.pages)))
    else $error("joined page count shrank");

  a_two_needs_final: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_o.cnt == 2'd2) |-> (accept_i && in_i.last && held_valid_q))
    else $error("double result without a final flush");
`endif

endmodule

[rtl/mrc_out_fifo.sv]
// ----------------------------------------------------------------------------
// mrc_out_fifo
// Four-entry result queue: up to two writes and one read per cycle.
// ----------------------------------------------------------------------------
module mrc_out_fifo (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  mrc_pkg::push_t  push_i,
  input  logic            pop_i,
  output logic            room_o,
  output logic            valid_o,
  output mrc_pkg::entry_t head_o
);

  mrc_pkg::entry_t mem_q [4];
  logic [1:0]      wr_q, wr_d;
  logic [1:0]      rd_q, rd_d;
  logic [2:0]      cnt_q, cnt_d;
  logic            pop;

  assign valid_o = (cnt_q != 3'd0);
  assign pop     = pop_i & valid_o;
  // Two free slots cover the worst-case beat count of one descriptor
  assign room_o  = (cnt_q <= 3'd2);
  assign head_o  = mem_q[rd_q];

  assign wr_d  = wr_q + push_i.cnt;
  assign rd_d  = rd_q + {1'b0, pop};
  assign cnt_d = cnt_q + {1'b0, push_i.cnt} - {2'b00, pop};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 2'd0;
      rd_q  <= 2'd0;
      cnt_q <= 3'd0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i.cnt != 2'd0) begin
      mem_q[wr_q] <= push_i.e0;
    end
    if (push_i.cnt == 2'd2) begin
      mem_q[wr_q + 2'd1] <= push_i.e1;
    end
  end

`ifndef ASSERT_OFF
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q > 3'd2) |-> (push_i.cnt == 2'd0))
    else $error("result queue overflow");

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q <= 3'd4) && ((wr_q - rd_q) == cnt_q[1:0]))
    else $error("result queue pointers out of step");
`endif

endmodule
